// ----- rtl/core/chp_pkg.sv -----
package chp_pkg;

  localparam int NUM_CORES = 4;
  localparam int FRAC_BITS = 11;

  localparam int CMP_W = 17 + FRAC_BITS;

  localparam logic [3:0] CORE_MASK = 4'(((1 << NUM_CORES) - 1) & 'hE);
  localparam logic [3:0] CORE_ALL  = 4'((1 << NUM_CORES) - 1);

  localparam logic [9:0]  PERIOD_NORMAL = 10'd1000;
  localparam logic [9:0]  PERIOD_BUSY   = 10'd500;
  localparam logic [9:0]  PERIOD_RESUME = 10'd10;
  localparam logic [3:0]  BUSY_HOLD     = 4'd10;
  localparam logic [15:0] NEVER_FAIL    = 16'hFFFF;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_TOUCH   = 2'd1;
  localparam logic [1:0] MODE_SUSPEND = 2'd2;
  localparam logic [1:0] MODE_RESUME  = 2'd3;

  localparam logic [2:0] CFG_PLUG_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_ECO_MODE       = 3'd1;
  localparam logic [2:0] CFG_TOUCH_BOOST    = 3'd2;
  localparam logic [2:0] CFG_PROFILE_SEL    = 3'd3;
  localparam logic [2:0] CFG_HYSTERESIS     = 3'd4;
  localparam logic [2:0] CFG_LOAD_THRESHOLD = 3'd5;

  localparam logic [2:0] PROF_ECO     = 3'd3;
  localparam logic [2:0] PROF_DISABLE = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  online_mask;
    logic [19:0] avg_run_queue;
    logic [15:0] queue_depth;
    logic [15:0] elapsed_ms;
    logic [15:0] core1_load;
    logic [15:0] core2_load;
    logic [15:0] core3_load;
  } req_t;

  typedef struct packed {
    logic [3:0] up_mask;
    logic [3:0] down_mask;
    logic [9:0] sample_period_ms;
    logic [2:0] target_cores;
    logic       sustained_boost;
  } res_t;

  // level thresholds per profile, entry i for level i+1
  function automatic logic [15:0] level_thr(logic [2:0] sel, logic [1:0] i);
    logic [15:0] v;
    v = 16'd0;
    case (sel)
      3'd0: begin
        case (i)
          2'd0: v = 16'd5;
          2'd1: v = 16'd7;
          default: v = 16'd9;
        endcase
      end
      3'd1: begin
        case (i)
          2'd0: v = 16'd3;
          2'd1: v = 16'd5;
          default: v = 16'd7;
        endcase
      end
      3'd2: begin
        case (i)
          2'd0: v = 16'd5;
          2'd1: v = 16'd13;
          default: v = 16'd14;
        endcase
      end
      3'd3: begin
        case (i)
          2'd0: v = 16'd3;
          default: v = NEVER_FAIL;
        endcase
      end
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] depth_thr(logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd19;
      3'd1: v = 8'd30;
      3'd2: v = 8'd19;
      3'd3: v = 8'd11;
      3'd4: v = 8'd19;
      3'd5: v = 8'd11;
      3'd6: v = 8'd0;
      default: v = 8'd11;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] time_thr(logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'd140;
      3'd1: v = 8'd0;
      3'd2: v = 8'd140;
      3'd3: v = 8'd190;
      3'd4: v = 8'd140;
      3'd5: v = 8'd190;
      3'd6: v = 8'd0;
      default: v = 8'd190;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] hold_time(logic [2:0] count, logic hit);
    logic [3:0] v;
    case (count)
      3'd2: v = hit ? 4'd7 : 4'd3;
      3'd3: v = hit ? 4'd5 : 4'd2;
      3'd4: v = hit ? 4'd3 : 4'd1;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/core_hotplug_policy.sv -----
// channel   dir  handshake                    payload
// request   in   req_valid / req_ready        req (chp_pkg::req_t)
// result    out  res_valid / res_ready        res (chp_pkg::res_t)
// config    in   cfg_we (no wait)             cfg_index, cfg_data
//
// a request is registered in s1, decided combinationally, and its result registered
// in res once that register is free; one request per cycle sustained while results are taken.
// the rate is set by the single decision stage between the two registers.
// a stalled result holds the decision stage; the request side keeps taking
// requests as long as that stage is empty or moving. rst is synchronous.
module core_hotplug_policy (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  chp_pkg::req_t      req,
  output logic               res_valid,
  input  logic               res_ready,
  output chp_pkg::res_t      res,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  chp_pkg::req_t s1;
  logic          s1_valid;
  logic          s1_advance;
  chp_pkg::res_t res_next;

  logic        plug_enable;
  logic        eco_mode;
  logic        touch_boost;
  logic [2:0]  profile_sel;
  logic [7:0]  hysteresis;
  logic [15:0] load_threshold;

  logic [2:0]  last_level,        last_level_next;
  logic [3:0]  busy_countdown,    busy_countdown_next;
  logic [3:0]  persist_countdown, persist_countdown_next;
  logic [9:0]  period_ms,         period_ms_next;
  logic        asleep,            asleep_next;
  logic [31:0] stable_time_ms,    stable_time_ms_next;
  logic        first_eval,        first_eval_next;

  logic [3:0]            online;
  logic [2:0]            n;
  logic [2:0]            sel;
  logic [2:0]            lvl;
  logic [2:0]            count;
  logic [3:0]            pc;
  logic [2:0]            fail;
  logic [16:0]           thr;
  logic [chp_pkg::CMP_W-1:0] avg_ext;
  logic [32:0]           sum;
  logic [31:0]           acc;
  logic [2:0]            idx;
  logic                  hit;
  logic [2:0][15:0]      loads;

  function automatic logic [3:0] bring_up(logic [3:0] on, logic [2:0] cnt);
    logic [3:0] m;
    m = 4'd0;
    for (int c = 1; c < 4; c++) begin
      if (3'(c) < cnt) m[c] = 1'b1;
    end
    return m & ~on & chp_pkg::CORE_MASK;
  endfunction

  function automatic logic [3:0] take_down(logic [3:0] on, logic [2:0] keep,
                                           logic [2:0][15:0] ld, logic [15:0] lim);
    logic [3:0] m;
    m = 4'd0;
    for (int c = 1; c < 4; c++) begin
      if (on[c] && 3'(c) > keep && ld[c-1] < lim) m[c] = 1'b1;
    end
    return m & chp_pkg::CORE_MASK;
  endfunction

  assign s1_advance = s1_valid && (!res_valid || res_ready);
  assign req_ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      s1 <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (s1_advance) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plug_enable    <= 1'b0;
      eco_mode       <= 1'b0;
      touch_boost    <= 1'b1;
      profile_sel    <= 3'd0;
      hysteresis     <= 8'd8;
      load_threshold <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chp_pkg::CFG_PLUG_ENABLE:    plug_enable    <= cfg_data[0];
        chp_pkg::CFG_ECO_MODE:       eco_mode       <= cfg_data[0];
        chp_pkg::CFG_TOUCH_BOOST:    touch_boost    <= cfg_data[0];
        chp_pkg::CFG_PROFILE_SEL:    profile_sel    <= cfg_data[2:0];
        chp_pkg::CFG_HYSTERESIS:     hysteresis     <= cfg_data[7:0];
        chp_pkg::CFG_LOAD_THRESHOLD: load_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level        <= 3'd0;
      busy_countdown    <= 4'd0;
      persist_countdown <= 4'd0;
      period_ms         <= chp_pkg::PERIOD_NORMAL;
      asleep            <= 1'b0;
      stable_time_ms    <= 32'd0;
      first_eval        <= 1'b1;
    end else if (s1_advance) begin
      last_level        <= last_level_next;
      busy_countdown    <= busy_countdown_next;
      persist_countdown <= persist_countdown_next;
      period_ms         <= period_ms_next;
      asleep            <= asleep_next;
      stable_time_ms    <= stable_time_ms_next;
      first_eval        <= first_eval_next;
    end
  end

  // decision stage
  always_comb begin
    last_level_next        = last_level;
    busy_countdown_next    = busy_countdown;
    persist_countdown_next = persist_countdown;
    period_ms_next         = period_ms;
    asleep_next            = asleep;
    stable_time_ms_next    = stable_time_ms;
    first_eval_next        = first_eval;

    res_next.up_mask          = 4'd0;
    res_next.down_mask        = 4'd0;
    res_next.sample_period_ms = period_ms;
    res_next.target_cores     = 3'd0;
    res_next.sustained_boost  = 1'b0;

    online = (s1.online_mask | 4'd1) & chp_pkg::CORE_ALL;
    n = 3'd0;
    for (int i = 0; i < 4; i++) begin
      n = n + {2'd0, online[i]};
    end
    loads = {s1.core3_load, s1.core2_load, s1.core1_load};

    // level thresholds with hysteresis
    sel = eco_mode ? chp_pkg::PROF_ECO :
          (profile_sel > chp_pkg::PROF_DISABLE ? chp_pkg::PROF_DISABLE : profile_sel);
    avg_ext = chp_pkg::CMP_W'(s1.avg_run_queue);
    for (int i = 0; i < 3; i++) begin
      thr = {1'b0, chp_pkg::level_thr(sel, 2'(i))}
          + ((last_level <= 3'(i + 1)) ? {9'd0, hysteresis} : 17'd0);
      if (eco_mode) begin
        fail[i] = avg_ext > (chp_pkg::CMP_W'(thr) << (chp_pkg::FRAC_BITS - 1));
      end else begin
        fail[i] = avg_ext > (chp_pkg::CMP_W'(thr) << (chp_pkg::FRAC_BITS - 3));
      end
    end
    if (eco_mode) begin
      lvl = fail[0] ? 3'd2 : 3'd1;
    end else if (!fail[0]) begin
      lvl = 3'd1;
    end else if (!fail[1]) begin
      lvl = 3'd2;
    end else if (!fail[2]) begin
      lvl = 3'd3;
    end else begin
      lvl = 3'd4;
    end

    // sustained load
    idx = 3'((n - 3'd1) << 1);
    sum = {1'b0, stable_time_ms} + {17'd0, s1.elapsed_ms};
    if (first_eval) begin
      acc = stable_time_ms;
    end else begin
      acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    hit   = 1'b0;
    count = lvl;
    pc    = 4'd0;

    case (s1.mode)
      chp_pkg::MODE_TOUCH: begin
        if (touch_boost && n < 3'd2) res_next.up_mask = bring_up(online, 3'd2);
      end
      chp_pkg::MODE_SUSPEND: begin
        asleep_next        = 1'b1;
        res_next.down_mask = online & chp_pkg::CORE_MASK;
      end
      chp_pkg::MODE_RESUME: begin
        persist_countdown_next    = chp_pkg::BUSY_HOLD;
        asleep_next               = 1'b0;
        res_next.up_mask          = bring_up(online,
                                      eco_mode ? 3'd2 : 3'(chp_pkg::NUM_CORES));
        res_next.sample_period_ms = chp_pkg::PERIOD_RESUME;
      end
      default: begin
        if (plug_enable) begin
          last_level_next = lvl;
          if (!eco_mode && n < 3'(chp_pkg::NUM_CORES)) begin
            first_eval_next = 1'b0;
            if (s1.queue_depth >= 16'(chp_pkg::depth_thr(idx))) begin
              hit = acc >= 32'(chp_pkg::time_thr(idx));
              stable_time_ms_next = acc;
            end else if (s1.queue_depth > 16'(chp_pkg::depth_thr(idx + 3'd1))) begin
              stable_time_ms_next = 32'd0;
            end else begin
              stable_time_ms_next = acc;
            end
            if (hit && (n == 3'd2 || n == 3'd3)) begin
              count = n + 3'd1;
              res_next.sustained_boost = 1'b1;
            end
          end

          if (count > 3'd2) begin
            if (busy_countdown == 4'd0) begin
              period_ms_next      = chp_pkg::PERIOD_BUSY;
              busy_countdown_next = chp_pkg::BUSY_HOLD;
            end
          end else if (busy_countdown > 4'd0) begin
            busy_countdown_next = busy_countdown - 4'd1;
          end else begin
            period_ms_next = chp_pkg::PERIOD_NORMAL;
          end

          if (!asleep) begin
            if (count == 3'd1) begin
              pc = (persist_countdown == 4'd0) ? 4'd0 : persist_countdown - 4'd1;
              persist_countdown_next = pc;
              if (pc == 4'd0) res_next.down_mask = take_down(online, 3'd0, loads,
                                                             load_threshold);
            end else if (count >= 3'd2 && count <= 3'd4) begin
              persist_countdown_next = chp_pkg::hold_time(count, hit);
              if (n < count) begin
                res_next.up_mask = bring_up(online, count);
              end else if (count < 3'd4) begin
                res_next.down_mask = take_down(online, count - 3'd1, loads,
                                               load_threshold);
              end
            end
          end

          res_next.target_cores     = count;
          res_next.sample_period_ms = period_ms_next;
        end
      end
    endcase
  end

endmodule

// ----- tb/sv/tb_core_hotplug_policy.sv -----
module tb_core_hotplug_policy;
  import chp_pkg::*;

  localparam logic [2:0] PROF_BALANCE      = 3'd0;
  localparam logic [2:0] PROF_UNUSED_HI    = 3'd7;
  localparam int         CYCLE_LIMIT       = 200000;
  localparam int         NUM_PHASES        = 10;

  class hotplug_scoreboard;
    bit          en_plug;
    bit          en_eco;
    bit          en_touch;
    logic [2:0]  prof_code;
    logic [7:0]  hyst_add;
    logic [15:0] load_floor;
    logic [2:0]  prev_level;
    logic [3:0]  busy_left;
    logic [3:0]  hold_left;
    logic [9:0]  cur_period;
    bit          sleeping;
    bit          first_pass;
    logic [31:0] stable_ms;
    res_t        awaited[$];
    int          errs;
    int unsigned depth_lim[8];
    int unsigned time_lim[8];
    int unsigned level_lim[5][3];
    int unsigned hold_tab[5][2];

    function new();
      en_plug    = 1'b0;
      en_eco     = 1'b0;
      en_touch   = 1'b1;
      prof_code  = PROF_BALANCE;
      hyst_add   = 8'd8;
      load_floor = 16'd50;
      prev_level = 3'd0;
      busy_left  = 4'd0;
      hold_left  = 4'd0;
      cur_period = PERIOD_NORMAL;
      sleeping   = 1'b0;
      first_pass = 1'b1;
      stable_ms  = 32'd0;
      errs       = 0;
      depth_lim  = '{19, 30, 19, 11, 19, 11, 0, 11};
      time_lim   = '{140, 0, 140, 190, 140, 190, 0, 190};
      level_lim  = '{'{5, 7, 9}, '{3, 5, 7}, '{5, 13, 14}, '{3, 'hFFFF, 'hFFFF}, '{0, 0, 0}};
      hold_tab   = '{'{0, 0}, '{0, 0}, '{3, 7}, '{2, 5}, '{1, 3}};
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        CFG_PLUG_ENABLE:    en_plug = v[0];
        CFG_ECO_MODE:       en_eco = v[0];
        CFG_TOUCH_BOOST:    en_touch = v[0];
        CFG_PROFILE_SEL:    prof_code = v[2:0];
        CFG_HYSTERESIS:     hyst_add = v[7:0];
        CFG_LOAD_THRESHOLD: load_floor = v;
        default: ;
      endcase
    endfunction

    function int ones(logic [3:0] m);
      int n;
      n = 0;
      for (int i = 0; i < 4; i++) n += m[i];
      return n;
    endfunction

    function logic [3:0] drop_mask(logic [3:0] online, int keep, req_t r);
      logic [15:0] ld [1:3];
      logic [3:0]  m;
      ld[1] = r.core1_load;
      ld[2] = r.core2_load;
      ld[3] = r.core3_load;
      m = 4'd0;
      for (int c = 1; c < 4; c++)
        if (online[c] && c > keep && ld[c] < load_floor) m[c] = 1'b1;
      return m & CORE_MASK;
    endfunction

    function logic [3:0] raise_mask(logic [3:0] online, int cnt);
      logic [3:0] m;
      m = 4'd0;
      for (int c = 1; c < cnt && c < 4; c++) m[c] = 1'b1;
      return m & ~online & CORE_MASK;
    endfunction

    function int pick_level(logic [19:0] avg);
      int          size;
      int          shift;
      int          sel;
      int          lvl;
      logic [63:0] thr;
      if (en_eco) begin
        sel   = PROF_ECO;
        size  = 2;
        shift = FRAC_BITS - 1;
      end else begin
        sel   = (prof_code > PROF_DISABLE) ? PROF_DISABLE : prof_code;
        size  = 4;
        shift = FRAC_BITS - 3;
      end
      for (lvl = 1; lvl < size; lvl++) begin
        thr = 64'(level_lim[sel][lvl-1]);
        if (prev_level <= lvl) thr += 64'(hyst_add);
        if (64'(avg) <= (thr << shift)) break;
      end
      prev_level = 3'(lvl);
      return lvl;
    endfunction

    function bit sustained_load(int n, logic [15:0] depth, logic [15:0] elapsed);
      int          idx;
      logic [32:0] sum;
      bit          hit;
      idx = (n - 1) * 2;
      hit = 1'b0;
      if (first_pass) begin
        first_pass = 1'b0;
      end else begin
        sum       = {1'b0, stable_ms} + 33'(elapsed);
        stable_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
      if (depth >= depth_lim[idx]) begin
        if (stable_ms >= time_lim[idx]) hit = 1'b1;
      end else if (depth > depth_lim[idx+1]) begin
        stable_ms = 32'd0;
      end
      return hit;
    endfunction

    // advance the policy state by one request and queue its decision
    function res_t note(req_t r);
      logic [3:0] online;
      int         n;
      int         cnt;
      bit         hit;
      res_t       e;
      online = (r.online_mask | 4'd1) & CORE_ALL;
      n = ones(online);
      hit = 1'b0;
      e = '0;
      e.sample_period_ms = cur_period;
      case (r.mode)
        MODE_TOUCH: begin
          if (en_touch && n < 2) e.up_mask = raise_mask(online, 2);
        end
        MODE_SUSPEND: begin
          sleeping = 1'b1;
          e.down_mask = online & CORE_MASK;
        end
        MODE_RESUME: begin
          hold_left = BUSY_HOLD;
          sleeping = 1'b0;
          e.up_mask = raise_mask(online, en_eco ? 2 : NUM_CORES);
          e.sample_period_ms = PERIOD_RESUME;
        end
        MODE_TICK: begin
          if (en_plug) begin
            cnt = pick_level(r.avg_run_queue);
            if (!en_eco && n >= 1 && n < NUM_CORES) begin
              hit = sustained_load(n, r.queue_depth, r.elapsed_ms);
              if (hit && (n == 2 || n == 3)) begin
                cnt = n + 1;
                e.sustained_boost = 1'b1;
              end
            end
            if (cnt > 2) begin
              if (busy_left == 4'd0) begin
                cur_period = PERIOD_BUSY;
                busy_left = BUSY_HOLD;
              end
            end else if (busy_left > 4'd0) begin
              busy_left--;
            end else begin
              cur_period = PERIOD_NORMAL;
            end
            if (!sleeping) begin
              if (cnt == 1) begin
                if (hold_left > 4'd0) hold_left--;
                if (hold_left == 4'd0) e.down_mask = drop_mask(online, 0, r);
              end else if (cnt >= 2 && cnt <= 4) begin
                hold_left = 4'(hold_tab[cnt][hit]);
                if (n < cnt) e.up_mask = raise_mask(online, cnt);
                else if (cnt < 4) e.down_mask = drop_mask(online, cnt - 1, r);
              end
            end
            e.target_cores = 3'(cnt);
            e.sample_period_ms = cur_period;
          end
        end
      endcase
      awaited.push_back(e);
      return e;
    endfunction

    task report(string what);
      if (errs < 100) $display("error at %0t: %s", $time, what);
      errs++;
    endtask

    task check(res_t got);
      res_t e;
      if (awaited.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = awaited.pop_front();
      if (got.up_mask !== e.up_mask)
        report($sformatf("up_mask %0h, expected %0h", got.up_mask, e.up_mask));
      if (got.down_mask !== e.down_mask)
        report($sformatf("down_mask %0h, expected %0h", got.down_mask, e.down_mask));
      if (got.sample_period_ms !== e.sample_period_ms)
        report($sformatf("sample_period_ms %0d, expected %0d",
                         got.sample_period_ms, e.sample_period_ms));
      if (got.target_cores !== e.target_cores)
        report($sformatf("target_cores %0d, expected %0d", got.target_cores, e.target_cores));
      if (got.sustained_boost !== e.sustained_boost)
        report($sformatf("sustained_boost %0b, expected %0b",
                         got.sustained_boost, e.sustained_boost));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  hotplug_scoreboard sb = new();
  int unsigned       cycles = 0;
  int unsigned       ready_hold = 0;
  bit                rx_calm = 1'b0;
  bit                tx_calm = 1'b0;
  logic [3:0]        live_mask = 4'h1;
  int                depth_band = 0;

  core_hotplug_policy u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ready = 1'b0;
    end else if (ready_hold > 0) begin
      res_ready = 1'b0;
      ready_hold--;
    end else begin
      res_ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      sb.check(res);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      ready_hold = rx_calm ? 0 : $urandom_range(0, 4);
    end
  end

  function automatic req_t mk(logic [1:0] m, logic [3:0] on, logic [19:0] avg,
                              logic [15:0] dep, logic [15:0] el, logic [15:0] ld);
    req_t r;
    r.mode = m;
    r.online_mask = on;
    r.avg_run_queue = avg;
    r.queue_depth = dep;
    r.elapsed_ms = el;
    r.core1_load = ld;
    r.core2_load = ld;
    r.core3_load = ld;
    return r;
  endfunction

  function automatic logic [15:0] rand_load();
    return ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 120)) : 16'($urandom);
  endfunction

  // mostly ticks on the tracked online set, with depth held in bands
  function automatic req_t rand_req();
    req_t r;
    int   p;
    int   units;
    int   shift;
    p = $urandom_range(0, 99);
    r.mode = (p < 76) ? MODE_TICK : (p < 86) ? MODE_TOUCH : (p < 92) ? MODE_SUSPEND : MODE_RESUME;
    r.online_mask = ($urandom_range(0, 9) < 7) ? live_mask : 4'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      r.avg_run_queue = 20'($urandom);
    end else begin
      shift = sb.en_eco ? FRAC_BITS - 1 : FRAC_BITS - 3;
      units = $urandom_range(0, int'(sb.hyst_add) + 20);
      r.avg_run_queue = 20'(units << shift) +
        20'(($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 1));
    end
    if ($urandom_range(0, 7) == 0) depth_band = $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) r.queue_depth = 16'($urandom);
    else if (depth_band == 0) r.queue_depth = 16'($urandom_range(19, 40));
    else if (depth_band == 1) r.queue_depth = 16'($urandom_range(12, 18));
    else r.queue_depth = 16'($urandom_range(0, 11));
    r.elapsed_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    r.core1_load = rand_load();
    r.core2_load = rand_load();
    r.core3_load = rand_load();
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int   gap;
    res_t e;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (!req_ready);
    e = sb.note(r);
    live_mask = (((r.online_mask | 4'd1) | e.up_mask) & ~e.down_mask) & CORE_ALL;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, val);
  endtask

  initial begin
    logic [15:0] hv;
    logic [15:0] tv;
    int          count;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_PLUG_ENABLE;
    cfg_data = 16'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings, ticks disabled
    send_req(mk(MODE_TICK, 4'hF, 20'hFFFFF, 16'd40, 16'd100, 16'd0));
    send_req(mk(MODE_TOUCH, 4'h1, 20'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_SUSPEND, 4'hF, 20'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_RESUME, 4'h1, 20'd0, 16'd0, 16'd0, 16'd0));

    write_reg(CFG_PLUG_ENABLE, 16'd1);
    write_reg(CFG_ECO_MODE, 16'd0);
    write_reg(CFG_TOUCH_BOOST, 16'd1);
    write_reg(CFG_PROFILE_SEL, 16'(PROF_BALANCE));
    write_reg(CFG_HYSTERESIS, 16'd8);
    write_reg(CFG_LOAD_THRESHOLD, 16'd50);

    send_req(mk(MODE_TICK, 4'h0, 20'd0, 16'd0, 16'hFFFF, 16'd0));
    send_req(mk(MODE_TICK, 4'hE, 20'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_req(mk(MODE_TICK, 4'hF, 20'hFFFFF, 16'd0, 16'd0, 16'd0));
    repeat (3) send_req(mk(MODE_TICK, 4'h3, 20'd0, 16'd30, 16'd200, 16'd0));
    send_req(mk(MODE_TICK, 4'h7, 20'd0, 16'd20, 16'd150, 16'd0));
    send_req(mk(MODE_TICK, 4'h3, 20'd0, 16'd15, 16'd10, 16'd0));
    send_req(mk(MODE_TICK, 4'h1, 20'd0, 16'd30, 16'd0, 16'd0));
    send_req(mk(MODE_TICK, 4'h3, 20'(13 << 8), 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_TOUCH, 4'h3, 20'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_SUSPEND, 4'hF, 20'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_TICK, 4'hF, 20'hFFFFF, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_RESUME, 4'h1, 20'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_TICK, 4'hF, 20'd0, 16'd0, 16'd0, 16'd0));

    write_reg(CFG_ECO_MODE, 16'd1);
    send_req(mk(MODE_TICK, 4'h1, 20'hFFFFF, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_TICK, 4'h3, 20'd0, 16'd0, 16'd0, 16'd0));
    send_req(mk(MODE_RESUME, 4'h1, 20'd0, 16'd0, 16'd0, 16'd0));
    write_reg(CFG_TOUCH_BOOST, 16'd0);
    send_req(mk(MODE_TOUCH, 4'h1, 20'd0, 16'd0, 16'd0, 16'd0));
    write_reg(CFG_ECO_MODE, 16'd0);
    write_reg(CFG_PROFILE_SEL, 16'(PROF_UNUSED_HI));
    send_req(mk(MODE_TICK, 4'hF, 20'h01000, 16'd0, 16'd0, 16'd0));
    write_reg(CFG_PROFILE_SEL, 16'(PROF_ECO));
    send_req(mk(MODE_TICK, 4'h1, 20'hFFFFF, 16'd0, 16'd0, 16'd0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: hv = 16'd8;
        1: hv = 16'd0;
        2: hv = 16'd255;
        default: hv = 16'($urandom_range(0, 255));
      endcase
      case (ph % 5)
        0: tv = 16'd50;
        1: tv = 16'd0;
        2: tv = 16'hFFFF;
        default: tv = 16'($urandom_range(0, 120));
      endcase
      write_reg(CFG_PLUG_ENABLE, (ph == 4) ? 16'd0 : 16'd1);
      write_reg(CFG_ECO_MODE, (ph % 4 == 2) ? 16'd1 : 16'd0);
      write_reg(CFG_TOUCH_BOOST, (ph % 3 != 1) ? 16'd1 : 16'd0);
      write_reg(CFG_PROFILE_SEL, 16'(ph % 8));
      write_reg(CFG_HYSTERESIS, hv);
      write_reg(CFG_LOAD_THRESHOLD, tv);
      count = (ph == 4) ? 20 : 75;
      repeat (count) send_req(rand_req());
    end

    @(negedge clk);
    req_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errs == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
